// File: rtl/core/prtd_pkg.sv
// Shared widths and types for the trial-division prime summer.
`default_nettype none
package prtd_pkg;

  // Candidate and running-sum widths
  localparam int VALUE_BITS = 20;
  localparam int SUM_BITS   = 48;

  // Divisor runs up to just past sqrt(2^VALUE_BITS)
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  // Square of the divisor can just exceed the largest candidate
  localparam int SQ_BITS    = VALUE_BITS + 1;
  // Bit counter of the remainder unit
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
  // Saturating adder width
  localparam int ADD_BITS   = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;

  // Fixed stream field widths
  localparam int CAND_W     = 20;
  localparam int OUT_SUM_W  = 48;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 56;

  // Remainder unit status toward the sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } prtd_div_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/prime_trial_division_summer.sv
// Top level: trial-division primality test with a saturating running sum of primes.
// Each candidate tries divisors from 2 upward, k <= floor(sqrt(candidate)) - 1 of them, each
//   through the remainder unit; a composite stops at its first divisor that leaves no remainder.
// One transaction at a time, paced by the bit-serial remainder unit; the result
//   waits in an output register, so the next transaction may be accepted meanwhile.
// Reset (rst, synchronous, active high) empties the sum and the flag and idles the sequencer.
`default_nettype none
module prime_trial_division_summer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // s_tdata, from bit 0: candidate[19:0], clear_sum[20], zero fill [23:21]
  input  wire logic [prtd_pkg::S_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // m_tdata, from bit 0: candidate_is_prime[0], prime_sum[48:1],
  // sum_saturated[49], zero fill [55:50]
  output logic [prtd_pkg::M_DATA_W-1:0]      m_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready
);
  import prtd_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] n;         // candidate under test
  logic [DIV_BITS-1:0]   d;         // current trial divisor
  logic [SQ_BITS-1:0]    sq;        // d*d, kept incrementally
  logic                  prime_flag;
  logic [SUM_BITS-1:0]   sum;
  logic                  sat;

  logic                  div_start;
  prtd_div_stat_t        div_stat;

  logic                  s_fire;
  logic                  m_fire;
  logic                  out_free;
  logic                  sq_past;
  logic [SQ_BITS-1:0]    sq_next;
  logic [ADD_BITS-1:0]   add_sum;
  logic                  add_over;
  logic [SUM_BITS-1:0]   sum_next;
  logic                  sat_next;

  localparam logic [ADD_BITS-1:0] SUM_TOP = ADD_BITS'({SUM_BITS{1'b1}});

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign out_free = !m_tvalid || m_tready;

  // Stop once d*d passes the candidate
  assign sq_past   = (sq > {1'b0, n});
  // (d+1)^2 = d^2 + 2d + 1
  assign sq_next   = sq + SQ_BITS'({d, 1'b1});
  assign div_start = (state == ST_CHECK) && !sq_past;

  // Saturating add of a prime into the running sum
  assign add_sum  = ADD_BITS'(sum) + ADD_BITS'(n);
  assign add_over = (add_sum > SUM_TOP);

  always_comb begin
    sum_next = sum;
    sat_next = sat;
    if (prime_flag) begin
      if (add_over) begin
        sum_next = {SUM_BITS{1'b1}};
        sat_next = 1'b1;
      end else begin
        sum_next = add_sum[SUM_BITS-1:0];
      end
    end
  end

  prtd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .stat     (div_stat)
  );

  // Sequencer and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sum      <= '0;
      sat      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Post a new result, or drop valid once the waiting one is taken
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_fire) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            // Clear ahead of the new candidate; the waiting result keeps its copy
            if (s_tdata[CAND_W]) begin
              sum <= '0;
              sat <= 1'b0;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sq_past) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= div_stat.rem_zero ? ST_DONE : ST_CHECK;
          end
        end
        ST_DONE: begin
          // Hold until the output register is free, then post the result
          if (out_free) begin
            sum      <= sum_next;
            sat      <= sat_next;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          n  <= VALUE_BITS'(s_tdata[CAND_W-1:0]);
          d  <= DIV_BITS'(2);
          sq <= SQ_BITS'(4);
        end
      end
      ST_CHECK: begin
        // No divisor left: prime unless the candidate is zero or one
        if (sq_past) begin
          prime_flag <= |n[VALUE_BITS-1:1];
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            prime_flag <= 1'b0;
          end else begin
            d  <= d + DIV_BITS'(1);
            sq <= sq_next;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {{(M_DATA_W - OUT_SUM_W - 2){1'b0}}, sat_next,
                      OUT_SUM_W'(sum_next), prime_flag};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/prtd_mod.sv
// Bit-serial restoring remainder unit: dividend mod divisor, one bit per cycle.
`default_nettype none
module prtd_mod (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [prtd_pkg::VALUE_BITS-1:0]   dividend,
  input  wire logic [prtd_pkg::DIV_BITS-1:0]     divisor,
  output prtd_pkg::prtd_div_stat_t               stat
);
  import prtd_pkg::*;

  logic [DIV_BITS-1:0]   rem;
  logic [VALUE_BITS-1:0] shf;
  logic [CNT_BITS-1:0]   cnt;
  logic                  busy;
  logic                  done;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  take;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem, shf[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      shf <= dividend;
    end else if (busy) begin
      rem <= take ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      shf <= {shf[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule
`default_nettype wire

// File: test/tb_prime_trial_division_summer.sv
// Testbench for the trial-division prime summer: directed and random stream traffic.
`default_nettype none
module tb_prime_trial_division_summer;
  import prtd_pkg::*;

  // Cycles without any transaction before the run is declared hung. The receiver
  // never stalls for long.
  localparam int IDLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS = 300;
  localparam int FILL_W       = S_DATA_W - CAND_W - 1;
  localparam logic [OUT_SUM_W-1:0] SUM_TOP = '1;

  // One result as the block reports it
  typedef struct packed {
    logic                 prime_flag;
    logic [OUT_SUM_W-1:0] sum;
    logic                 saturated;
  } prime_report_t;

  // Receiver behavior, picked anew at random intervals
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;

  // Running sum and sticky flag as the block should hold them
  logic [OUT_SUM_W-1:0] model_sum = '0;
  logic                 model_sat = 1'b0;
  prime_report_t        pending_reports[$];
  int                   error_count = 0;
  int                   burst_left  = 0;
  int                   idle_cycles = 0;
  rx_mode_t             rx_mode     = RX_ALWAYS;
  int                   rx_mode_cycles = 0;

  prime_trial_division_summer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Try every divisor whose square stays within the candidate.
  function automatic logic trial_div_prime(input logic [CAND_W-1:0] n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= 32'(n); d++)
      if (32'(n) % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Drive one candidate, hold it until accepted, then predict its result.
  // Between items the sender runs in bursts with random gaps.
  task automatic send_candidate(input logic [CAND_W-1:0] n, input logic clr);
    prime_report_t       r;
    logic [OUT_SUM_W:0]  wide;
    int                  gap;
    s_tdata  <= {{FILL_W{1'b0}}, clr, n};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    // Clear comes first, so a prime on a clearing item starts a fresh sum.
    if (clr) begin
      model_sum = '0;
      model_sat = 1'b0;
    end
    r.prime_flag = trial_div_prime(n);
    if (r.prime_flag) begin
      wide = {1'b0, model_sum} + (OUT_SUM_W+1)'(n);
      if (wide > {1'b0, SUM_TOP}) begin
        model_sum = SUM_TOP;
        model_sat = 1'b1;
      end else begin
        model_sum = wide[OUT_SUM_W-1:0];
      end
    end
    r.sum       = model_sum;
    r.saturated = model_sat;
    pending_reports.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic wait_all_reports();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Zero and one are never prime; two and three are the smallest primes.
  task automatic test_small_values();
    send_candidate(20'd0, 1'b1);
    send_candidate(20'd1, 1'b0);
    send_candidate(20'd2, 1'b0);
    send_candidate(20'd3, 1'b0);
    send_candidate(20'd4, 1'b0);
  endtask

  // Squares of primes hit the divisor bound exactly: d*d == n must be tried.
  task automatic test_squares();
    send_candidate(20'd25, 1'b0);
    send_candidate(20'd49, 1'b0);
    send_candidate(20'd121, 1'b0);
    send_candidate(20'd1018081, 1'b0);
  endtask

  // All-ones candidate, the largest 20-bit prime, and a Mersenne prime.
  task automatic test_extremes();
    send_candidate(20'hFFFFF, 1'b0);
    send_candidate(20'd1048573, 1'b0);
    send_candidate(20'd524287, 1'b0);
  endtask

  // Clear on a prime adds to an empty sum; clear on a non-prime leaves zero.
  task automatic test_clear();
    send_candidate(20'd7, 1'b1);
    send_candidate(20'd97, 1'b0);
    send_candidate(20'd0, 1'b1);
    send_candidate(20'd11, 1'b0);
  endtask

  // Let the block go fully idle, then resume with the sum carried over.
  task automatic test_idle_pause();
    send_candidate(20'd13, 1'b0);
    send_candidate(20'd15, 1'b0);
    wait_all_reports();
    send_candidate(20'd17, 1'b0);
    send_candidate(20'd1021, 1'b0);
  endtask

  // Mostly small candidates keep the run short; a tenth span the full width
  // so every candidate bit toggles. The 48-bit sum cannot fill up from 20-bit
  // primes in any practical run, so saturation stays unreached here.
  task automatic test_random();
    logic [CAND_W-1:0] n;
    int                pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      n = CAND_W'($urandom_range(0, 4095));
      else if (pick < 90) n = CAND_W'($urandom_range(0, 65535));
      else                n = CAND_W'($urandom);
      send_candidate(n, $urandom_range(0, 19) == 0);
      if (i == RANDOM_ITEMS / 2) wait_all_reports();
    end
  endtask

  // Receiver: pick a stall behavior for a stretch of cycles, then another.
  always @(posedge clk) begin
    if (rx_mode_cycles == 0) begin
      rx_mode        <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_cycles <= $urandom_range(50, 400);
    end else begin
      rx_mode_cycles <= rx_mode_cycles - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
      default:   m_tready <= (rx_mode_cycles % 16) < 10;
    endcase
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : check_reports
    prime_report_t want;
    prime_report_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.prime_flag = m_tdata[0];
      got.sum        = m_tdata[OUT_SUM_W:1];
      got.saturated  = m_tdata[OUT_SUM_W+1];
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.prime_flag !== want.prime_flag) begin
          $display("%0t: candidate_is_prime expected %0d actual %0d",
                   $time, want.prime_flag, got.prime_flag);
          error_count++;
        end
        if (got.sum !== want.sum) begin
          $display("%0t: prime_sum expected %0d actual %0d", $time, want.sum, got.sum);
          error_count++;
        end
        if (got.saturated !== want.saturated) begin
          $display("%0t: sum_saturated expected %0d actual %0d",
                   $time, want.saturated, got.saturated);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_small_values();
    test_squares();
    test_extremes();
    test_clear();
    test_idle_pause();
    test_random();
    wait_all_reports();
    // Catch any stray result after the last expected one.
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
